// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the hashing RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SHA_ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SHA_ASSERT_NXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Beat types, control structs, round constants and round functions for the
// SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } dgst_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] bdata;
    logic       step;
  } sched_ctl_t;

  typedef struct packed {
    logic       init;
    logic       load;
    logic       round;
    logic       fold;
    logic [5:0] rnd;
    logic [2:0] sel;
  } core_ctl_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;

  localparam word_t INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t major(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// ===== rtl/sha256_sched.sv =====
// ----------------------------------------------------------------------------
// sha256_sched
// Block buffer and message schedule window: bytes shift in during fill, and
// each round shifts out one schedule word while the next one is formed.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                   clk,
  input  sha256_pkg::sched_ctl_t ctl,
  output sha256_pkg::word_t      w_cur
);
  import sha256_pkg::*;

  logic [511:0] blk;
  word_t        w_new;

  assign w_cur = blk[511:480];
  assign w_new = blk[511:480] + small_sig0(blk[479:448]) + blk[223:192]
               + small_sig1(blk[63:32]);

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      blk <= {blk[503:0], ctl.bdata};
    end else if (ctl.step) begin
      blk <= {blk[479:0], w_new};
    end
  end

endmodule

// ===== rtl/sha256_core.sv =====
// ----------------------------------------------------------------------------
// sha256_core
// Chaining words and the shared round unit: one compression round per cycle,
// then a fold of the working words into the chaining words.
// ----------------------------------------------------------------------------
module sha256_core (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::core_ctl_t ctl,
  input  sha256_pkg::word_t     w_cur,
  output sha256_pkg::word_t     dword
);
  import sha256_pkg::*;

  word_t chain [8];
  word_t v [8];
  word_t t1;
  word_t t2;

  assign t1 = v[7] + big_sig1(v[4]) + choose(v[4], v[5], v[6]) + ROUND_K[ctl.rnd] + w_cur;
  assign t2 = big_sig0(v[0]) + major(v[0], v[1], v[2]);
  assign dword = chain[ctl.sel];

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      chain <= INIT_H;
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v <= chain;
    end else if (ctl.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

// ===== rtl/sha256_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_hasher
// SHA-256 over a byte stream with end marker; emits eight digest words.
// ----------------------------------------------------------------------------
//  channel   beat      handshake                meaning
//  msg       msg_t     msg_valid / msg_ready    one byte and/or end of message
//  dgst      dgst_t    dgst_valid / dgst_ready  one 32-bit digest word
//
//  Bytes go in one per cycle while msg_ready is high; a full block is then
//  compressed round by round in the single round unit and folded.
//  The end beat adds padding bytes (9 to 64, or 65 to 72 with an extra block)
//  at one per cycle, each block's compression, then eight digest beats.
//  msg_ready is low while padding, compressing or emitting; a stalled digest
//  word holds the sequencer only during the digest phase.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sha256_hasher (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  output logic              msg_ready,
  input  sha256_pkg::msg_t  msg_beat,
  output logic              dgst_valid,
  input  logic              dgst_ready,
  output sha256_pkg::dgst_t dgst_beat
);
  import sha256_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_PAD    = 5'b00010,
    ST_ROUNDS = 5'b00100,
    ST_FOLD   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t      state;
  logic [5:0]  fill;
  logic [63:0] bitlen;
  logic [5:0]  rnd;
  logic        msg_end;
  logic        marked;
  logic        two_block;
  logic        len_done;
  logic [2:0]  osel;

  logic        msg_fire;
  logic        is_len;
  logic        pad_tail;
  logic [7:0]  pad_byte;
  logic        enter_rounds;
  logic        emit_load;
  sched_ctl_t  sctl;
  core_ctl_t   cctl;
  word_t       w_cur;
  word_t       dword;

  assign msg_ready    = (state == ST_IDLE);
  assign msg_fire     = msg_valid && msg_ready;
  assign is_len       = marked && (fill >= LEN_POS) && !two_block;
  assign pad_tail     = (state == ST_PAD) && (fill == LAST_POS);
  assign pad_byte     = !marked ? PAD_MARK : (is_len ? bitlen[63:56] : 8'h00);
  assign emit_load    = (state == ST_EMIT) && (!dgst_valid || dgst_ready);

  assign sctl.shift_byte = (msg_fire && msg_beat.byte_valid) || (state == ST_PAD);
  assign sctl.bdata      = (state == ST_PAD) ? pad_byte : msg_beat.msg_byte;
  assign sctl.step       = (state == ST_ROUNDS);

  assign enter_rounds = sctl.shift_byte && (fill == LAST_POS);

  assign cctl.init  = emit_load && (osel == 3'd7);
  assign cctl.load  = enter_rounds;
  assign cctl.round = (state == ST_ROUNDS);
  assign cctl.fold  = (state == ST_FOLD);
  assign cctl.rnd   = rnd;
  assign cctl.sel   = osel;

  sha256_sched u_sched (
    .clk   (clk),
    .ctl   (sctl),
    .w_cur (w_cur)
  );

  sha256_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cctl),
    .w_cur (w_cur),
    .dword (dword)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      bitlen     <= '0;
      rnd        <= '0;
      msg_end    <= 1'b0;
      marked     <= 1'b0;
      two_block  <= 1'b0;
      len_done   <= 1'b0;
      osel       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (msg_fire) begin
            msg_end <= msg_beat.end_of_message;
            if (msg_beat.byte_valid) begin
              fill   <= fill + 6'd1;
              bitlen <= bitlen + 64'd8;
            end
            if (enter_rounds) begin
              state <= ST_ROUNDS;
            end else if (msg_beat.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fill <= fill + 6'd1;
          if (!marked) begin
            marked <= 1'b1;
            if (fill != LAST_POS) begin
              two_block <= (fill >= LEN_POS);
            end
          end else if (is_len) begin
            bitlen <= {bitlen[55:0], bitlen[63:56]};
            if (fill == LAST_POS) begin
              len_done <= 1'b1;
            end
          end
          if (fill == LAST_POS) begin
            two_block <= 1'b0;
            state     <= ST_ROUNDS;
          end
        end
        ST_ROUNDS: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (len_done) begin
            state <= ST_EMIT;
          end else if (msg_end) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            osel <= osel + 3'd1;
            if (osel == 3'd7) begin
              state    <= ST_IDLE;
              fill     <= '0;
              bitlen   <= '0;
              msg_end  <= 1'b0;
              marked   <= 1'b0;
              len_done <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dgst_valid <= 1'b0;
    end else if (emit_load) begin
      dgst_valid <= 1'b1;
    end else if (dgst_ready) begin
      dgst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      dgst_beat.digest_word <= dword;
      dgst_beat.word_index  <= osel;
      dgst_beat.last_word   <= (osel == 3'd7);
    end
  end

  `SHA_ASSERT_NXT(a_rounds_end, clk, rst, state == ST_ROUNDS && rnd == 6'd63, state == ST_FOLD)
  `SHA_ASSERT_NXT(a_len_tail, clk, rst, pad_tail && is_len, state == ST_ROUNDS && len_done)
  `SHA_ASSERT_IMP(a_rnd_start, clk, rst, enter_rounds, rnd == 6'd0)
  `SHA_ASSERT_NXT(a_msg_clear, clk, rst, cctl.init, state == ST_IDLE && fill == 6'd0 && bitlen == 64'd0)

endmodule
